// File: hdl/c6502_pkg.sv
// Package for the 6502 bus-cycle core: phase, addressing mode, flag and opcode constants.
// Used by c6502_decode and cpu_6502_instruction_execute.
`default_nettype none
package c6502_pkg;

  typedef enum logic [10:0] {
    PH_IDLE   = 11'b000_0000_0001,
    PH_FETCH  = 11'b000_0000_0010,
    PH_OPLO   = 11'b000_0000_0100,
    PH_OPHI   = 11'b000_0000_1000,
    PH_PTRLO  = 11'b000_0001_0000,
    PH_PTRHI  = 11'b000_0010_0000,
    PH_DATA   = 11'b000_0100_0000,
    PH_WDONE  = 11'b000_1000_0000,
    PH_PULLLO = 11'b001_0000_0000,
    PH_PULLHI = 11'b010_0000_0000,
    PH_PUSH2  = 11'b100_0000_0000
  } phase_t;

  typedef enum logic [4:0] {
    M_BAD, M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY,
    M_INX, M_INY, M_REL, M_JMPA, M_JMPI, M_JSR, M_RTS, M_PUSH, M_PULL
  } mode_t;

  localparam int FB_C = 0;
  localparam int FB_Z = 1;
  localparam int FB_D = 3;
  localparam int FB_V = 6;
  localparam int FB_N = 7;

  localparam logic [7:0] OP_PHA = 8'h48;
  localparam logic [7:0] OP_PLA = 8'h68;
  localparam logic [7:0] OP_PLP = 8'h28;

endpackage
`default_nettype wire

// File: hdl/c6502_decode.sv
// Opcode decoder: maps an opcode byte to its addressing mode.
// Depends on c6502_pkg.
`default_nettype none
module c6502_decode
  import c6502_pkg::*;
(
  input  wire logic [7:0] op,
  output mode_t           mode
);

  always_comb begin
    mode = M_BAD;
    if (op[1:0] == 2'b01) begin
      if (op == 8'h89) mode = M_BAD;
      else begin
        case (op[4:2])
          3'd0: mode = M_INX;
          3'd1: mode = M_ZP;
          3'd2: mode = M_IMM;
          3'd3: mode = M_ABS;
          3'd4: mode = M_INY;
          3'd5: mode = M_ZPX;
          3'd6: mode = M_ABY;
          default: mode = M_ABX;
        endcase
      end
    end else begin
      case (op) inside
        8'hA2, 8'hA0, 8'hE0, 8'hC0: mode = M_IMM;
        8'hA6, 8'hA4, 8'h86, 8'h84, 8'hE4, 8'hC4, 8'h24, 8'h06, 8'h46, 8'h26,
        8'h66, 8'hE6, 8'hC6: mode = M_ZP;
        8'hB4, 8'h94, 8'h16, 8'h56, 8'h36, 8'h76, 8'hF6, 8'hD6: mode = M_ZPX;
        8'hB6, 8'h96: mode = M_ZPY;
        8'hAE, 8'hAC, 8'h8E, 8'h8C, 8'hEC, 8'hCC, 8'h2C, 8'h0E, 8'h4E, 8'h2E,
        8'h6E, 8'hEE, 8'hCE: mode = M_ABS;
        8'hBC, 8'h1E, 8'h5E, 8'h3E, 8'h7E, 8'hFE, 8'hDE: mode = M_ABX;
        8'hBE: mode = M_ABY;
        8'h8A, 8'hAA, 8'h98, 8'hA8, 8'h9A, 8'hBA, 8'hE8, 8'hCA, 8'hC8, 8'h88,
        8'h38, 8'hF8, 8'h18, 8'hD8, 8'hB8, 8'h0A, 8'h4A, 8'h2A, 8'h6A: mode = M_IMP;
        8'h48, 8'h08: mode = M_PUSH;
        8'h68, 8'h28: mode = M_PULL;
        8'h60: mode = M_RTS;
        8'h20: mode = M_JSR;
        8'h4C: mode = M_JMPA;
        8'h6C: mode = M_JMPI;
        8'h90, 8'hB0, 8'hF0, 8'hD0, 8'h50, 8'h70, 8'h30, 8'h10: mode = M_REL;
        default: mode = M_BAD;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/cpu_6502_instruction_execute.sv
// 6502 bus-cycle core: one beat in (start or bus completion), one bus request out.
// Each accepted beat's request is registered in the output register.
// Throughput: one beat per clock unless the output stalls; the output register holds a request
// under stall, and the next beat is taken only when the output register frees up.
// Reset (rst_n, synchronous): A/X/Y/P = 0, S = 0xFF, PC = 0, phase idle, no output.
// Depends on c6502_pkg and c6502_decode.
`default_nettype none
module cpu_6502_instruction_execute
  import c6502_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_read_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_bus_addr,
  output logic             out_bus_write,
  output logic [7:0]       out_bus_wdata,
  output logic             out_opcode_fetch,
  output logic             out_bad_opcode
);

  logic [15:0] start_r;
  logic [7:0]  a_r, x_r, y_r, s_r, p_r, op_r, lat_r;
  logic [15:0] pc_r, ea_r;
  phase_t      ph_r;
  logic [7:0]  a_nxt, x_nxt, y_nxt, s_nxt, p_nxt, op_nxt, lat_nxt;
  logic [15:0] pc_nxt, ea_nxt;
  phase_t      ph_nxt;

  logic        ov_r;
  logic [15:0] addr_r, addr_nxt;
  logic        wr_r, wr_nxt, fe_r, fe_nxt, bad_r, bad_nxt;
  logic [7:0]  wd_r, wd_nxt;

  logic        take;
  mode_t       mode_cur, mode_new, m;
  logic [7:0]  op, d;

  assign in_stall = ov_r & out_stall;
  assign take     = in_valid & ~in_stall;
  assign d        = in_read_data;

  c6502_decode u_dec_cur (.op(op_r), .mode(mode_cur));
  c6502_decode u_dec_new (.op(d),    .mode(mode_new));

  // ALU helpers, and the flags variable f
  logic [7:0] f;

  function automatic logic [7:0] nz(input logic [7:0] fl, input logic [7:0] v);
    logic [7:0] r;
    r = fl;
    r[FB_Z] = (v == 8'h00);
    r[FB_N] = v[7];
    return r;
  endfunction

  function automatic logic [7:0] shres(input logic [7:0] o, input logic [7:0] v,
                                       input logic c);
    case (o[7:5])
      3'd0: shres = {v[6:0], 1'b0};
      3'd1: shres = {v[6:0], c};
      3'd2: shres = {1'b0, v[7:1]};
      3'd3: shres = {c, v[7:1]};
      3'd6: shres = v - 8'd1;
      default: shres = v + 8'd1;
    endcase
  endfunction

  function automatic logic shc(input logic [7:0] o, input logic [7:0] v, input logic c);
    case (o[7:5])
      3'd0, 3'd1: shc = v[7];
      3'd2, 3'd3: shc = v[0];
      default: shc = c;
    endcase
  endfunction

  logic [8:0] sum;
  logic [7:0] addv, sh_r;
  logic [8:0] cmp_d;
  logic [7:0] cmp_reg;
  logic [15:0] abs_a, ptr_a;
  logic        taken;
  logic [15:0] pcm1;

  always_comb begin
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; s_nxt = s_r; p_nxt = p_r;
    op_nxt = op_r; lat_nxt = lat_r; pc_nxt = pc_r; ea_nxt = ea_r; ph_nxt = ph_r;
    addr_nxt = pc_r; wr_nxt = 1'b0; wd_nxt = 8'h00; fe_nxt = 1'b0; bad_nxt = 1'b0;
    op = op_r;
    m  = mode_cur;
    f  = p_r;
    addv = 8'h00; sum = 9'h000; sh_r = 8'h00; cmp_reg = 8'h00;
    cmp_d = 9'h000; taken = 1'b0;
    abs_a = {d, lat_r};
    ptr_a = {d, lat_r};
    pcm1  = pc_r;

    if (!in_req_type) begin
      pc_nxt = start_r; addr_nxt = start_r; fe_nxt = 1'b1; ph_nxt = PH_FETCH;
    end else begin
      case (ph_r)
        PH_FETCH: begin
          op_nxt = d; op = d; m = mode_new;
          pc_nxt = pc_r + 16'd1;
          case (mode_new)
            M_BAD: begin
              addr_nxt = pc_nxt; fe_nxt = 1'b1; bad_nxt = 1'b1; ph_nxt = PH_FETCH;
            end
            M_IMP: begin
              case (d)
                8'h8A: begin a_nxt = x_r; f = nz(f, x_r); end
                8'hAA: begin x_nxt = a_r; f = nz(f, a_r); end
                8'h98: begin a_nxt = y_r; f = nz(f, y_r); end
                8'hA8: begin y_nxt = a_r; f = nz(f, a_r); end
                8'h9A: s_nxt = x_r;
                8'hBA: begin x_nxt = s_r; f = nz(f, s_r); end
                8'hE8: begin x_nxt = x_r + 8'd1; f = nz(f, x_nxt); end
                8'hCA: begin x_nxt = x_r - 8'd1; f = nz(f, x_nxt); end
                8'hC8: begin y_nxt = y_r + 8'd1; f = nz(f, y_nxt); end
                8'h88: begin y_nxt = y_r - 8'd1; f = nz(f, y_nxt); end
                8'h38: f[FB_C] = 1'b1;
                8'hF8: f[FB_D] = 1'b1;
                8'h18: f[FB_C] = 1'b0;
                8'hD8: f[FB_D] = 1'b0;
                8'hB8: f[FB_V] = 1'b0;
                default: begin
                  sh_r = shres(d, a_r, p_r[FB_C]);
                  f[FB_C] = shc(d, a_r, p_r[FB_C]);
                  f = nz(f, sh_r);
                  a_nxt = sh_r;
                end
              endcase
              p_nxt = f;
              addr_nxt = pc_nxt; fe_nxt = 1'b1; ph_nxt = PH_FETCH;
            end
            M_PUSH: begin
              addr_nxt = {8'h01, s_r}; wr_nxt = 1'b1;
              wd_nxt = (d == OP_PHA) ? a_r : (p_r | 8'h30);
              s_nxt = s_r - 8'd1; ph_nxt = PH_WDONE;
            end
            M_PULL, M_RTS: begin
              s_nxt = s_r + 8'd1; addr_nxt = {8'h01, s_nxt}; ph_nxt = PH_PULLLO;
            end
            default: begin
              addr_nxt = pc_nxt; ph_nxt = PH_OPLO;
            end
          endcase
        end
        PH_OPLO: begin
          pc_nxt = pc_r + 16'd1;
          case (m)
            M_IMM: begin
              addr_nxt = pc_nxt; fe_nxt = 1'b1; ph_nxt = PH_FETCH;
            end
            M_REL: begin
              taken = 1'b0;
              case (op[7:6])
                2'd0: taken = p_r[FB_N];
                2'd1: taken = p_r[FB_V];
                2'd2: taken = p_r[FB_C];
                default: taken = p_r[FB_Z];
              endcase
              if (taken == op[5]) pc_nxt = pc_r + 16'd1 + {{8{d[7]}}, d};
              addr_nxt = pc_nxt; fe_nxt = 1'b1; ph_nxt = PH_FETCH;
            end
            M_ZP:  ea_nxt = {8'h00, d};
            M_ZPX: ea_nxt = {8'h00, d + x_r};
            M_ZPY: ea_nxt = {8'h00, d + y_r};
            M_INX: begin
              ea_nxt = {8'h00, d + x_r}; addr_nxt = ea_nxt; ph_nxt = PH_PTRLO;
            end
            M_INY: begin
              ea_nxt = {8'h00, d}; addr_nxt = ea_nxt; ph_nxt = PH_PTRLO;
            end
            default: begin
              lat_nxt = d; addr_nxt = pc_nxt; ph_nxt = PH_OPHI;
            end
          endcase
        end
        PH_OPHI: begin
          pc_nxt = pc_r + 16'd1;
          case (m)
            M_ABS: ea_nxt = abs_a;
            M_ABX: ea_nxt = abs_a + {8'h00, x_r};
            M_ABY: ea_nxt = abs_a + {8'h00, y_r};
            M_JMPA: begin
              pc_nxt = abs_a; addr_nxt = abs_a; fe_nxt = 1'b1; ph_nxt = PH_FETCH;
            end
            M_JMPI: begin
              ea_nxt = abs_a; addr_nxt = abs_a; ph_nxt = PH_PTRLO;
            end
            default: begin
              // JSR: push high byte of the address of its last byte (pc_r)
              ea_nxt = abs_a;
              addr_nxt = {8'h01, s_r}; wr_nxt = 1'b1; wd_nxt = pc_r[15:8];
              s_nxt = s_r - 8'd1; ph_nxt = PH_PUSH2;
            end
          endcase
        end
        PH_PTRLO: begin
          lat_nxt = d;
          addr_nxt = {ea_r[15:8], ea_r[7:0] + 8'd1};
          ph_nxt = PH_PTRHI;
        end
        PH_PTRHI: begin
          if (m == M_JMPI) begin
            pc_nxt = ptr_a; addr_nxt = ptr_a; fe_nxt = 1'b1; ph_nxt = PH_FETCH;
          end else begin
            ea_nxt = (m == M_INY) ? ptr_a + {8'h00, y_r} : ptr_a;
          end
        end
        PH_DATA: begin
          if (op[1:0] == 2'b10 && op[7:5] != 3'd4 && op[7:5] != 3'd5) begin
            sh_r = shres(op, d, p_r[FB_C]);
            f[FB_C] = shc(op, d, p_r[FB_C]);
            p_nxt = nz(f, sh_r);
            addr_nxt = ea_r; wr_nxt = 1'b1; wd_nxt = sh_r; ph_nxt = PH_WDONE;
          end else begin
            addr_nxt = pc_r; fe_nxt = 1'b1; ph_nxt = PH_FETCH;
          end
        end
        PH_PUSH2: begin
          pcm1 = pc_r - 16'd1;
          addr_nxt = {8'h01, s_r}; wr_nxt = 1'b1; wd_nxt = pcm1[7:0];
          s_nxt = s_r - 8'd1; pc_nxt = ea_r; ph_nxt = PH_WDONE;
        end
        PH_WDONE: begin
          addr_nxt = pc_r; fe_nxt = 1'b1; ph_nxt = PH_FETCH;
        end
        PH_PULLLO: begin
          if (op == OP_PLA) begin
            a_nxt = d; p_nxt = nz(p_r, d);
            addr_nxt = pc_r; fe_nxt = 1'b1; ph_nxt = PH_FETCH;
          end else if (op == OP_PLP) begin
            p_nxt = d & 8'hCF;
            addr_nxt = pc_r; fe_nxt = 1'b1; ph_nxt = PH_FETCH;
          end else begin
            lat_nxt = d; s_nxt = s_r + 8'd1; addr_nxt = {8'h01, s_nxt};
            ph_nxt = PH_PULLHI;
          end
        end
        PH_PULLHI: begin
          pc_nxt = ptr_a + 16'd1; addr_nxt = pc_nxt; fe_nxt = 1'b1; ph_nxt = PH_FETCH;
        end
        default: begin
          addr_nxt = pc_r; ph_nxt = PH_IDLE;
        end
      endcase

      // memory operand start for modes that have their address now
      if ((ph_r == PH_OPLO && (m == M_ZP || m == M_ZPX || m == M_ZPY)) ||
          (ph_r == PH_OPHI && (m == M_ABS || m == M_ABX || m == M_ABY)) ||
          (ph_r == PH_PTRHI && m != M_JMPI)) begin
        addr_nxt = ea_nxt; ph_nxt = PH_DATA;
        if (op[1:0] == 2'b01 && op[7:5] == 3'd4) begin
          wr_nxt = 1'b1; wd_nxt = a_r; ph_nxt = PH_WDONE;
        end else if (op == 8'h86 || op == 8'h96 || op == 8'h8E) begin
          wr_nxt = 1'b1; wd_nxt = x_r; ph_nxt = PH_WDONE;
        end else if (op == 8'h84 || op == 8'h94 || op == 8'h8C) begin
          wr_nxt = 1'b1; wd_nxt = y_r; ph_nxt = PH_WDONE;
        end
      end

      // read-side operations (immediate and data phase loads/ALU)
      if ((ph_r == PH_OPLO && m == M_IMM) ||
          (ph_r == PH_DATA && !(op[1:0] == 2'b10 && op[7:5] != 3'd4 &&
                                op[7:5] != 3'd5))) begin
        f = p_r;
        if (op[1:0] == 2'b01) begin
          addv = (op[7:5] == 3'd7) ? ~d : d;
          sum  = {1'b0, a_r} + {1'b0, addv} + {8'h00, p_r[FB_C]};
          cmp_d = {1'b0, a_r} - {1'b0, d};
          case (op[7:5])
            3'd0: begin a_nxt = a_r | d; f = nz(f, a_nxt); end
            3'd1: begin a_nxt = a_r & d; f = nz(f, a_nxt); end
            3'd2: begin a_nxt = a_r ^ d; f = nz(f, a_nxt); end
            3'd3, 3'd7: begin
              a_nxt = sum[7:0];
              f[FB_C] = sum[8];
              f[FB_V] = ~(a_r[7] ^ addv[7]) & (a_r[7] ^ sum[7]);
              f = nz(f, sum[7:0]);
            end
            3'd5: begin a_nxt = d; f = nz(f, d); end
            3'd6: begin f[FB_C] = ~cmp_d[8]; f = nz(f, cmp_d[7:0]); end
            default: ;
          endcase
        end else if (op[1:0] == 2'b10) begin
          x_nxt = d; f = nz(f, d);
        end else begin
          cmp_reg = (op[7:5] == 3'd6) ? y_r : x_r;
          cmp_d = {1'b0, cmp_reg} - {1'b0, d};
          case (op[7:5])
            3'd1: begin
              f[FB_Z] = ((a_r & d) == 8'h00); f[FB_N] = d[7]; f[FB_V] = d[6];
            end
            3'd5: begin y_nxt = d; f = nz(f, d); end
            default: begin f[FB_C] = ~cmp_d[8]; f = nz(f, cmp_d[7:0]); end
          endcase
        end
        p_nxt = f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 16'h0000;
      a_r <= 8'h00; x_r <= 8'h00; y_r <= 8'h00; s_r <= 8'hFF; p_r <= 8'h00;
      op_r <= 8'h00; lat_r <= 8'h00; pc_r <= 16'h0000; ea_r <= 16'h0000;
      ph_r <= PH_IDLE; ov_r <= 1'b0;
    end else begin
      if (cfg_we) start_r <= cfg_wdata;
      if (take) begin
        a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; s_r <= s_nxt; p_r <= p_nxt;
        op_r <= op_nxt; lat_r <= lat_nxt; pc_r <= pc_nxt; ea_r <= ea_nxt;
        ph_r <= ph_nxt;
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      addr_r <= addr_nxt; wr_r <= wr_nxt; wd_r <= wd_nxt;
      fe_r <= fe_nxt; bad_r <= bad_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_bus_addr     = addr_r;
  assign out_bus_write    = wr_r;
  assign out_bus_wdata    = wd_r;
  assign out_opcode_fetch = fe_r;
  assign out_bad_opcode   = bad_r;

  // start beat always yields an opcode fetch at start address
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    take && !in_req_type |=> out_valid && out_opcode_fetch && !out_bus_write)
    else $error("start did not issue a fetch");

  a_bad_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_opcode |-> out_opcode_fetch)
    else $error("bad opcode flag without fetch");

  a_stack_wr: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_req_type && ph_r == PH_PUSH2 |=> out_bus_write && out_bus_addr[15:8] == 8'h01)
    else $error("JSR second push not on stack page");

  a_fetch_phase: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_req_type && ph_r == PH_WDONE |=> ph_r == PH_FETCH && out_opcode_fetch)
    else $error("write completion did not fetch");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for cpu_6502_instruction_execute: the bench acts as memory,
// takes each expected request from its own 6502 model or a typed row, and compares each result beat.
// Depends on c6502_pkg and the core RTL.
`default_nettype none
module tb_top
  import c6502_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] OP_UNDEF   = 8'h02;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_ADC_IMM = 8'h69;
  localparam logic [7:0] OP_SBC_IMM = 8'hE9;
  localparam logic [7:0] OP_BCS     = 8'hB0;
  localparam logic [7:0] OP_JSR     = 8'h20;
  localparam logic [7:0] OP_RTS     = 8'h60;
  localparam logic [7:0] OP_JMP_IND = 8'h6C;
  localparam logic [7:0] OP_TXA = 8'h8A, OP_TAX = 8'hAA, OP_TYA = 8'h98, OP_TAY = 8'hA8;
  localparam logic [7:0] OP_TXS = 8'h9A, OP_TSX = 8'hBA, OP_INX = 8'hE8, OP_DEX = 8'hCA;
  localparam logic [7:0] OP_INY = 8'hC8, OP_DEY = 8'h88, OP_SEC = 8'h38, OP_SED = 8'hF8;
  localparam logic [7:0] OP_CLC = 8'h18, OP_CLD = 8'hD8, OP_CLV = 8'hB8;
  localparam logic [7:0] OP_STX_ZP = 8'h86, OP_STX_ZPY = 8'h96, OP_STX_ABS = 8'h8E;
  localparam logic [7:0] OP_STY_ZP = 8'h84, OP_STY_ZPX = 8'h94, OP_STY_ABS = 8'h8C;
  localparam logic [7:0] OP_BIT_DUMMY = 8'h89;
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DONE  = 1'b1;
  localparam int   CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [15:0] addr;
    logic        wr;
    logic [7:0]  wd;
    logic        fetch;
    logic        bad;
  } bus_req_t;

  typedef struct {
    logic     req;
    logic [7:0] d;
    logic     typed;
    bus_req_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b1;
  logic [7:0]  in_read_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_bus_addr;
  logic        out_bus_write;
  logic [7:0]  out_bus_wdata;
  logic        out_opcode_fetch;
  logic        out_bad_opcode;

  cpu_6502_instruction_execute DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_read_data(in_read_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_bus_addr(out_bus_addr), .out_bus_write(out_bus_write),
    .out_bus_wdata(out_bus_wdata), .out_opcode_fetch(out_opcode_fetch),
    .out_bad_opcode(out_bad_opcode)
  );

  always #1 clk = ~clk;

  // predicted core state
  logic [15:0] start_addr;
  logic [7:0]  acc, rx, ry, sp, pf, cur_op, latch;
  logic [15:0] pc, ea;
  phase_t      cpu_phase;

  bus_req_t    pending_reqs[$];
  bus_req_t    last_req;
  logic [7:0]  mem [0:65535];
  logic [7:0]  legal_ops[$];
  int          errors = 0;
  int          cycles = 0;
  bit          gaps_on = 1'b1;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int          stall_pct = 15;

  function automatic mode_t op_mode(input logic [7:0] op);
    if (op[1:0] == 2'b01) begin
      if (op == OP_BIT_DUMMY) return M_BAD;
      case (op[4:2])
        3'd0: return M_INX;
        3'd1: return M_ZP;
        3'd2: return M_IMM;
        3'd3: return M_ABS;
        3'd4: return M_INY;
        3'd5: return M_ZPX;
        3'd6: return M_ABY;
        default: return M_ABX;
      endcase
    end
    // opcode map for the non-ALU groups
    case (op)
      8'hA2, 8'hA0, 8'hE0, 8'hC0: return M_IMM;
      8'hA6, 8'hA4, 8'h86, 8'h84, 8'hE4, 8'hC4, 8'h24, 8'h06, 8'h46, 8'h26, 8'h66,
      8'hE6, 8'hC6: return M_ZP;
      8'hB4, 8'h94, 8'h16, 8'h56, 8'h36, 8'h76, 8'hF6, 8'hD6: return M_ZPX;
      8'hB6, 8'h96: return M_ZPY;
      8'hAE, 8'hAC, 8'h8E, 8'h8C, 8'hEC, 8'hCC, 8'h2C, 8'h0E, 8'h4E, 8'h2E, 8'h6E,
      8'hEE, 8'hCE: return M_ABS;
      8'hBC, 8'h1E, 8'h5E, 8'h3E, 8'h7E, 8'hFE, 8'hDE: return M_ABX;
      8'hBE: return M_ABY;
      8'h8A, 8'hAA, 8'h98, 8'hA8, 8'h9A, 8'hBA, 8'hE8, 8'hCA, 8'hC8, 8'h88, 8'h38,
      8'hF8, 8'h18, 8'hD8, 8'hB8, 8'h0A, 8'h4A, 8'h2A, 8'h6A: return M_IMP;
      OP_PHA, 8'h08: return M_PUSH;
      OP_PLA, OP_PLP: return M_PULL;
      OP_RTS: return M_RTS;
      OP_JSR: return M_JSR;
      8'h4C: return M_JMPA;
      OP_JMP_IND: return M_JMPI;
      8'h90, 8'hB0, 8'hF0, 8'hD0, 8'h50, 8'h70, 8'h30, 8'h10: return M_REL;
      default: return M_BAD;
    endcase
  endfunction

  function automatic void set_nz(input logic [7:0] v);
    pf[FB_Z] = (v == 8'd0);
    pf[FB_N] = v[7];
  endfunction

  function automatic void add_carry(input logic [7:0] v);
    logic [8:0] sum;
    logic [7:0] r;
    sum = {1'b0, acc} + {1'b0, v} + {8'd0, pf[FB_C]};
    r = sum[7:0];
    pf[FB_C] = sum[8];
    pf[FB_V] = (~(acc[7] ^ v[7])) & (acc[7] ^ r[7]);
    acc = r;
    set_nz(r);
  endfunction

  function automatic void compare_reg(input logic [7:0] rg, input logic [7:0] v);
    pf[FB_C] = (rg >= v);
    set_nz(rg - v);
  endfunction

  function automatic logic [7:0] shift_or_step(input logic [7:0] op, input logic [7:0] v);
    logic       cin;
    logic [7:0] r;
    cin = pf[FB_C];
    case (op[7:5])
      3'd0: begin pf[FB_C] = v[7]; r = {v[6:0], 1'b0}; end
      3'd1: begin pf[FB_C] = v[7]; r = {v[6:0], cin}; end
      3'd2: begin pf[FB_C] = v[0]; r = {1'b0, v[7:1]}; end
      3'd3: begin pf[FB_C] = v[0]; r = {cin, v[7:1]}; end
      3'd6: r = v - 8'd1;
      default: r = v + 8'd1;
    endcase
    set_nz(r);
    return r;
  endfunction

  function automatic void apply_read(input logic [7:0] op, input logic [7:0] v);
    if (op[1:0] == 2'b01) begin
      case (op[7:5])
        3'd0: begin acc = acc | v; set_nz(acc); end
        3'd1: begin acc = acc & v; set_nz(acc); end
        3'd2: begin acc = acc ^ v; set_nz(acc); end
        3'd3: add_carry(v);
        3'd5: begin acc = v; set_nz(v); end
        3'd6: compare_reg(acc, v);
        3'd7: add_carry(~v);
        default: ;
      endcase
    end else if (op[1:0] == 2'b10) begin
      rx = v;
      set_nz(v);
    end else begin
      case (op[7:5])
        3'd1: begin
          pf[FB_Z] = ((acc & v) == 8'd0);
          pf[FB_N] = v[7];
          pf[FB_V] = v[6];
        end
        3'd5: begin ry = v; set_nz(v); end
        3'd6: compare_reg(ry, v);
        default: compare_reg(rx, v);
      endcase
    end
  endfunction

  function automatic void exec_implied(input logic [7:0] op);
    case (op)
      OP_TXA: begin acc = rx; set_nz(acc); end
      OP_TAX: begin rx = acc; set_nz(rx); end
      OP_TYA: begin acc = ry; set_nz(acc); end
      OP_TAY: begin ry = acc; set_nz(ry); end
      OP_TXS: sp = rx;
      OP_TSX: begin rx = sp; set_nz(rx); end
      OP_INX: begin rx = rx + 8'd1; set_nz(rx); end
      OP_DEX: begin rx = rx - 8'd1; set_nz(rx); end
      OP_INY: begin ry = ry + 8'd1; set_nz(ry); end
      OP_DEY: begin ry = ry - 8'd1; set_nz(ry); end
      OP_SEC: pf[FB_C] = 1'b1;
      OP_SED: pf[FB_D] = 1'b1;
      OP_CLC: pf[FB_C] = 1'b0;
      OP_CLD: pf[FB_D] = 1'b0;
      OP_CLV: pf[FB_V] = 1'b0;
      default: acc = shift_or_step(op, acc);
    endcase
  endfunction

  function automatic bus_req_t fetch_req(input logic bad);
    cpu_phase = PH_FETCH;
    return '{addr: pc, wr: 1'b0, wd: 8'd0, fetch: 1'b1, bad: bad};
  endfunction

  function automatic bus_req_t read_req(input logic [15:0] a);
    return '{addr: a, wr: 1'b0, wd: 8'd0, fetch: 1'b0, bad: 1'b0};
  endfunction

  function automatic bus_req_t push_req(input logic [7:0] v, input phase_t nxt);
    bus_req_t r;
    r = '{addr: {8'h01, sp}, wr: 1'b1, wd: v, fetch: 1'b0, bad: 1'b0};
    sp = sp - 8'd1;
    cpu_phase = nxt;
    return r;
  endfunction

  function automatic bus_req_t pull_req(input phase_t nxt);
    sp = sp + 8'd1;
    cpu_phase = nxt;
    return read_req({8'h01, sp});
  endfunction

  function automatic bus_req_t mem_access();
    bus_req_t r;
    r = read_req(ea);
    cpu_phase = PH_WDONE;
    if (cur_op[1:0] == 2'b01 && cur_op[7:5] == 3'd4) begin
      r.wr = 1'b1; r.wd = acc;
    end else if (cur_op == OP_STX_ZP || cur_op == OP_STX_ZPY || cur_op == OP_STX_ABS) begin
      r.wr = 1'b1; r.wd = rx;
    end else if (cur_op == OP_STY_ZP || cur_op == OP_STY_ZPX || cur_op == OP_STY_ABS) begin
      r.wr = 1'b1; r.wd = ry;
    end else begin
      cpu_phase = PH_DATA;
    end
    return r;
  endfunction

  // advance the predicted core by one accepted beat; returns the bus request it causes
  function automatic bus_req_t next_bus_request(input logic req, input logic [7:0] d);
    mode_t       m;
    logic [15:0] a;
    logic [7:0]  op;
    bus_req_t    r;
    if (req == REQ_START) begin
      pc = start_addr;
      return fetch_req(1'b0);
    end
    op = cur_op;
    m = op_mode(op);
    a = {d, latch};
    case (cpu_phase)
      PH_FETCH: begin
        cur_op = d;
        op = d;
        pc = pc + 16'd1;
        m = op_mode(op);
        if (m == M_BAD) r = fetch_req(1'b1);
        else if (m == M_IMP) begin exec_implied(op); r = fetch_req(1'b0); end
        else if (m == M_PUSH) r = push_req(op == OP_PHA ? acc : (pf | 8'h30), PH_WDONE);
        else if (m == M_PULL || m == M_RTS) r = pull_req(PH_PULLLO);
        else begin r = read_req(pc); cpu_phase = PH_OPLO; end
      end
      PH_OPLO: begin
        pc = pc + 16'd1;
        if (m == M_IMM) begin apply_read(op, d); r = fetch_req(1'b0); end
        else if (m == M_REL) begin
          if (pf[{op[7:6] == 2'd0 ? FB_N : op[7:6] == 2'd1 ? FB_V :
                  op[7:6] == 2'd2 ? FB_C : FB_Z}] == op[5])
            pc = pc + {{8{d[7]}}, d};
          r = fetch_req(1'b0);
        end else if (m == M_ZP) begin ea = {8'd0, d}; r = mem_access(); end
        else if (m == M_ZPX) begin ea = {8'd0, d + rx}; r = mem_access(); end
        else if (m == M_ZPY) begin ea = {8'd0, d + ry}; r = mem_access(); end
        else if (m == M_INX || m == M_INY) begin
          ea = {8'd0, (m == M_INX) ? d + rx : d};
          r = read_req(ea);
          cpu_phase = PH_PTRLO;
        end else begin
          latch = d;
          r = read_req(pc);
          cpu_phase = PH_OPHI;
        end
      end
      PH_OPHI: begin
        pc = pc + 16'd1;
        if (m == M_ABS) begin ea = a; r = mem_access(); end
        else if (m == M_ABX) begin ea = a + {8'd0, rx}; r = mem_access(); end
        else if (m == M_ABY) begin ea = a + {8'd0, ry}; r = mem_access(); end
        else if (m == M_JMPA) begin pc = a; r = fetch_req(1'b0); end
        else if (m == M_JMPI) begin ea = a; r = read_req(a); cpu_phase = PH_PTRLO; end
        else begin
          ea = a;
          a = pc - 16'd1;
          r = push_req(a[15:8], PH_PUSH2);
        end
      end
      PH_PTRLO: begin
        latch = d;
        r = read_req({ea[15:8], ea[7:0] + 8'd1});   // pointer high byte stays in page
        cpu_phase = PH_PTRHI;
      end
      PH_PTRHI: begin
        if (m == M_JMPI) begin pc = a; r = fetch_req(1'b0); end
        else begin
          ea = (m == M_INY) ? a + {8'd0, ry} : a;
          r = mem_access();
        end
      end
      PH_DATA: begin
        if (op[1:0] == 2'b10 && op[7:5] != 3'd4 && op[7:5] != 3'd5) begin
          r = read_req(ea);
          r.wr = 1'b1;
          r.wd = shift_or_step(op, d);
          cpu_phase = PH_WDONE;
        end else begin
          apply_read(op, d);
          r = fetch_req(1'b0);
        end
      end
      PH_PUSH2: begin
        a = pc - 16'd1;
        r = push_req(a[7:0], PH_WDONE);
        pc = ea;
      end
      PH_WDONE: r = fetch_req(1'b0);
      PH_PULLLO: begin
        if (op == OP_PLA) begin acc = d; set_nz(d); r = fetch_req(1'b0); end
        else if (op == OP_PLP) begin pf = d & 8'hCF; r = fetch_req(1'b0); end
        else begin latch = d; r = pull_req(PH_PULLHI); end
      end
      PH_PULLHI: begin
        pc = a + 16'd1;
        r = fetch_req(1'b0);
      end
      default: begin
        r = read_req(pc);
        cpu_phase = PH_IDLE;
      end
    endcase
    return r;
  endfunction

  task automatic send_beat(input logic req, input logic [7:0] d, input logic typed,
                           input bus_req_t want);
    bus_req_t p;
    in_valid <= 1'b1;
    in_req_type <= req;
    in_read_data <= d;
    do @(posedge clk); while (!(in_valid && !in_stall));
    p = next_bus_request(req, d);
    last_req = p;
    pending_reqs.push_back(typed ? want : p);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // the bench plays memory: answer the last predicted request, or at random send a start beat instead
  task automatic send_random_beat();
    logic [7:0] d;
    if ($urandom_range(0, 99) < 2) begin
      send_beat(REQ_START, 8'($urandom), 1'b0, '0);
    end else begin
      if (last_req.wr) mem[last_req.addr] = last_req.wd;
      if (last_req.fetch)
        d = ($urandom_range(0, 99) < 88) ? legal_ops[$urandom_range(0, legal_ops.size() - 1)]
                                          : 8'($urandom);
      else if (last_req.wr || $urandom_range(0, 19) == 0) d = 8'($urandom);
      else d = mem[last_req.addr];
      send_beat(REQ_DONE, d, 1'b0, '0);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reqs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_start_addr(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    start_addr = v;
    @(negedge clk);
  endtask

  // result beat checker
  always @(posedge clk) begin
    bus_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reqs.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat addr=%h wr=%b wd=%h fetch=%b bad=%b", $time,
                 out_bus_addr, out_bus_write, out_bus_wdata, out_opcode_fetch, out_bad_opcode);
      end else begin
        want = pending_reqs.pop_front();
        if (out_bus_addr !== want.addr || out_bus_write !== want.wr ||
            out_bus_wdata !== want.wd || out_opcode_fetch !== want.fetch ||
            out_bad_opcode !== want.bad) begin
          errors++;
          $display("%0t: mismatch expected addr=%h wr=%b wd=%h fetch=%b bad=%b", $time,
                   want.addr, want.wr, want.wd, want.fetch, want.bad);
          $display("%0t:          actual   addr=%h wr=%b wd=%h fetch=%b bad=%b", $time,
                   out_bus_addr, out_bus_write, out_bus_wdata, out_opcode_fetch,
                   out_bad_opcode);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** cpu_6502_instruction_execute: FAILED **");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    dir_row_t    rows[$];
    logic [15:0] phase_addr[5];
    for (int i = 0; i < 65536; i++) mem[i] = 8'($urandom);
    for (int i = 0; i < 256; i++) if (op_mode(8'(i)) != M_BAD) legal_ops.push_back(8'(i));
    start_addr = 16'd0;
    acc = 8'd0; rx = 8'd0; ry = 8'd0; sp = 8'hFF; pf = 8'd0; pc = 16'd0;
    cur_op = 8'd0; ea = 16'd0; latch = 8'd0; cpu_phase = PH_IDLE;
    last_req = '0;

    rows.push_back('{REQ_DONE, 8'h00, 1'b1, '{16'h0000, 1'b0, 8'h00, 1'b0, 1'b0}});
    rows.push_back('{REQ_START, 8'hFF, 1'b1, '{16'h1234, 1'b0, 8'h00, 1'b1, 1'b0}});
    rows.push_back('{REQ_DONE, OP_LDA_IMM, 1'b1, '{16'h1235, 1'b0, 8'h00, 1'b0, 1'b0}});
    rows.push_back('{REQ_DONE, 8'h80, 1'b1, '{16'h1236, 1'b0, 8'h00, 1'b1, 1'b0}});
    rows.push_back('{REQ_DONE, OP_UNDEF, 1'b1, '{16'h1237, 1'b0, 8'h00, 1'b1, 1'b1}});
    rows.push_back('{REQ_DONE, OP_ADC_IMM, 1'b0, '0});
    rows.push_back('{REQ_DONE, 8'h80, 1'b0, '0});   // signed overflow, carry out, zero
    rows.push_back('{REQ_DONE, OP_BCS, 1'b0, '0});
    rows.push_back('{REQ_DONE, 8'h80, 1'b0, '0});   // backward branch
    rows.push_back('{REQ_DONE, OP_PHA, 1'b0, '0});
    rows.push_back('{REQ_DONE, 8'h00, 1'b0, '0});
    rows.push_back('{REQ_DONE, OP_JSR, 1'b0, '0});
    rows.push_back('{REQ_DONE, 8'hFF, 1'b0, '0});
    rows.push_back('{REQ_DONE, 8'hFF, 1'b0, '0});
    rows.push_back('{REQ_DONE, 8'h00, 1'b0, '0});
    rows.push_back('{REQ_DONE, 8'h00, 1'b0, '0});
    rows.push_back('{REQ_DONE, OP_RTS, 1'b0, '0});
    rows.push_back('{REQ_DONE, 8'h3F, 1'b0, '0});
    rows.push_back('{REQ_DONE, 8'h12, 1'b0, '0});
    rows.push_back('{REQ_DONE, OP_JMP_IND, 1'b0, '0});
    rows.push_back('{REQ_DONE, 8'hFF, 1'b0, '0});
    rows.push_back('{REQ_DONE, 8'h10, 1'b0, '0});   // pointer crosses a page: wraps
    rows.push_back('{REQ_DONE, 8'h34, 1'b0, '0});
    rows.push_back('{REQ_DONE, 8'h12, 1'b0, '0});
    rows.push_back('{REQ_DONE, OP_SBC_IMM, 1'b0, '0});
    rows.push_back('{REQ_DONE, 8'hFF, 1'b0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_start_addr(16'h1234);
    foreach (rows[i]) send_beat(rows[i].req, rows[i].d, rows[i].typed, rows[i].want);
    drain();

    phase_addr = '{16'hFFFF, 16'h0000, 16'($urandom), 16'hFFFE, 16'($urandom)};
    for (int ph = 0; ph < 5; ph++) begin
      write_start_addr(phase_addr[ph]);
      stall_pct = (ph == 1) ? 0 : 15;
      if (ph == 4) begin
        quiet = 1'b1;
        gaps_on = 1'b0;
      end
      send_beat(REQ_START, 8'($urandom), 1'b0, '0);
      for (int i = 0; i < 335; i++) begin
        if (ph == 2 && i == 100) hold_req = 1'b1;
        send_random_beat();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** cpu_6502_instruction_execute: PASSED **");
    end else begin
      $display("** cpu_6502_instruction_execute: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
